// ===== hw/rtl/leb_pkg.sv =====
`timescale 1ns / 1ps
package leb_pkg;

  localparam int unsigned BufDepth  = 1024;
  localparam int unsigned PendDepth = 256;
  localparam int unsigned BufAw     = $clog2(BufDepth);
  localparam int unsigned PendAw    = $clog2(PendDepth);
  localparam int unsigned LenW      = BufAw + 1;
  localparam int unsigned PlenW     = PendAw + 1;

  typedef enum logic [2:0] {
    CMD_RIGHT  = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_SET    = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_BACK   = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] arg;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [10:0] view_length;
    logic [10:0] cursor_pos;
    logic        editing;
    logic [1:0]  status;
  } out_word_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture input word
    logic exec;       // apply simple command
    logic cmt_init;   // set up commit
    logic shift_rd;   // issue tail read
    logic shift_wr;   // write tail byte
    logic copy_rd;    // issue pending read
    logic copy_wr;    // write pending byte
    logic cmt_done;   // finish commit
    logic rd_issue;   // issue view read
    logic respond;    // emit result
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_move;
    logic is_read;
    logic need_commit;
    logic shift_last;
    logic shift_empty;
    logic copy_last;
    logic copy_empty;
  } sts_t;

endpackage

// ===== hw/rtl/leb_ram.sv =====
`timescale 1ns / 1ps
module leb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/leb_ctrl.sv =====
`timescale 1ns / 1ps
module leb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  leb_pkg::sts_t  sts_i,
  output leb_pkg::ctl_t  ctl_o
);
  import leb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DECODE = 8'b00000010,
    S_SHIFT  = 8'b00000100,
    S_SHWR   = 8'b00001000,
    S_COPY   = 8'b00010000,
    S_CPWR   = 8'b00100000,
    S_READ   = 8'b01000000,
    S_EXEC   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // next state and command decode
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_move && sts_i.need_commit) begin
          ctl_o.cmt_init = 1'b1;
          state_d = S_SHIFT;
        end else if (sts_i.is_read) begin
          ctl_o.rd_issue = 1'b1;
          state_d = S_READ;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_empty) begin
          state_d = S_COPY;
        end else begin
          ctl_o.shift_rd = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl_o.shift_wr = 1'b1;
        state_d = sts_i.shift_last ? S_COPY : S_SHIFT;
      end
      S_COPY: begin
        if (sts_i.copy_empty) begin
          ctl_o.cmt_done = 1'b1;
          state_d = S_EXEC;
        end else begin
          ctl_o.copy_rd = 1'b1;
          state_d = S_CPWR;
        end
      end
      S_CPWR: begin
        ctl_o.copy_wr = 1'b1;
        state_d = S_COPY;
      end
      // RAM data from the issue cycle is on the read port here
      S_READ: begin
        ctl_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      S_EXEC: begin
        ctl_o.exec    = 1'b1;
        ctl_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/leb_dpath.sv =====
`timescale 1ns / 1ps
module leb_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  leb_pkg::in_word_t  in_i,
  input  leb_pkg::ctl_t      ctl_i,
  output leb_pkg::sts_t      sts_o,
  output leb_pkg::out_word_t out_o,
  output logic               strobe_o
);
  import leb_pkg::*;

  localparam logic [LenW-1:0]  BufFull  = LenW'(BufDepth);
  localparam logic [PlenW-1:0] PendFull = PlenW'(PendDepth);

  in_word_t          in_q;
  logic [LenW-1:0]   len_q, cur_q, back_q, fwd_q;
  logic [PlenW-1:0]  plen_q;
  logic              open_q;
  out_word_t         out_q;
  logic              strobe_q;

  // commit pointers: shift source/dest, copy index
  logic [LenW-1:0]   src_q, dst_q, cnt_q;
  logic [PlenW-1:0]  cp_q;
  logic              rd_sel_q;   // view read: 1 = pending store

  logic              tx_we, px_we;
  logic [BufAw-1:0]  tx_wa, tx_ra;
  logic [7:0]        tx_wd, tx_rd;
  logic [PendAw-1:0] px_wa, px_ra;
  logic [7:0]        px_rd;

  logic [LenW-1:0]   view_len, left, tail_from;
  logic [16:0]       arg_x;
  cmd_e              cmd;

  assign cmd       = cmd_e'(in_q.cmd);
  assign arg_x     = {1'b0, in_q.arg};
  assign left      = cur_q - back_q;
  assign tail_from = cur_q + fwd_q;
  assign view_len  = open_q ? LenW'(len_q + LenW'(plen_q) - back_q - fwd_q) : len_q;

  // status to controller
  always_comb begin
    sts_o.is_move     = (cmd == CMD_RIGHT) || (cmd == CMD_LEFT) || (cmd == CMD_SET);
    sts_o.is_read     = (cmd == CMD_READ) && (arg_x < 17'(view_len));
    sts_o.need_commit = open_q;
    sts_o.shift_empty = (cnt_q == '0);
    sts_o.shift_last  = (cnt_q == LenW'(1));
    sts_o.copy_empty  = (cp_q == plen_q);
    sts_o.copy_last   = (cp_q + PlenW'(1) == plen_q);
  end

  // view read address mapping
  logic [LenW-1:0] vidx, vrel, vtail;
  always_comb begin
    vidx  = in_q.arg[LenW-1:0];
    vrel  = vidx - left;
    vtail = tail_from + vrel - LenW'(plen_q);
  end

  // RAM port steering; the shift runs end-first when the tail moves up
  always_comb begin
    tx_we = 1'b0;
    tx_wa = dst_q[BufAw-1:0];
    tx_wd = tx_rd;
    tx_ra = src_q[BufAw-1:0];
    px_ra = cp_q[PendAw-1:0];
    px_we = 1'b0;
    px_wa = plen_q[PendAw-1:0];
    if (ctl_i.shift_wr) tx_we = 1'b1;
    if (ctl_i.copy_wr) begin
      tx_we = 1'b1;
      tx_wa = BufAw'(left + LenW'(cp_q) - LenW'(1));
      tx_wd = px_rd;
    end
    if (ctl_i.rd_issue) begin
      if (!open_q || vidx < left) tx_ra = vidx[BufAw-1:0];
      else if (vrel < LenW'(plen_q)) px_ra = vrel[PendAw-1:0];
      else tx_ra = vtail[BufAw-1:0];
    end
    if (ctl_i.exec && cmd == CMD_INSERT && !(open_q && (view_len >= BufFull
        || plen_q >= PendFull))) begin
      px_we = 1'b1;
      px_wa = open_q ? plen_q[PendAw-1:0] : '0;
    end
  end

  leb_ram #(.Width(8), .Depth(BufDepth)) u_text (
    .clk_i, .we_i(tx_we), .waddr_i(tx_wa), .wdata_i(tx_wd),
    .raddr_i(tx_ra), .rdata_o(tx_rd)
  );

  leb_ram #(.Width(8), .Depth(PendDepth)) u_pend (
    .clk_i, .we_i(px_we), .waddr_i(px_wa), .wdata_i(in_q.arg[7:0]),
    .raddr_i(px_ra), .rdata_o(px_rd)
  );

  // shift direction: moving toward higher addresses copies from the end
  logic [LenW-1:0] tail_len, newleft;
  logic            up;
  assign tail_len = len_q - tail_from;
  assign newleft  = left + LenW'(plen_q);
  assign up       = newleft > tail_from;

  logic [LenW-1:0] mv;
  logic [LenW:0]   sum;
  logic [LenW-1:0] room, k, bk, lft;
  logic [PlenW-1:0] pk;
  always_comb begin
    mv  = (arg_x > 17'(BufFull)) ? BufFull : in_q.arg[LenW-1:0];
    sum = {1'b0, cur_q} + {1'b0, mv};
    room = len_q - cur_q - fwd_q;
    pk  = (arg_x < 17'(plen_q)) ? in_q.arg[PlenW-1:0] : plen_q;
    bk  = (arg_x - 17'(pk) < 17'(left)) ? LenW'(arg_x - 17'(pk)) : left;
    k   = (arg_x < 17'(room)) ? in_q.arg[LenW-1:0] : room;
    // left move stops at zero, then clamps to a length shrunk by the commit
    lft = (arg_x > 17'(cur_q)) ? '0 : LenW'(17'(cur_q) - arg_x);
    if (lft > len_q) lft = len_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) in_q <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; cur_q <= '0; back_q <= '0; fwd_q <= '0;
      plen_q <= '0; open_q <= 1'b0; strobe_q <= 1'b0;
      src_q <= '0; dst_q <= '0; cnt_q <= '0; cp_q <= '0; rd_sel_q <= 1'b0;
    end else begin
      strobe_q <= ctl_i.respond;
      if (ctl_i.cmt_init) begin
        cnt_q <= tail_len;
        cp_q  <= '0;
        src_q <= up ? LenW'(len_q - LenW'(1)) : tail_from;
        dst_q <= up ? LenW'(newleft + tail_len - LenW'(1)) : newleft;
      end
      if (ctl_i.shift_wr) begin
        cnt_q <= cnt_q - LenW'(1);
        src_q <= up ? src_q - LenW'(1) : src_q + LenW'(1);
        dst_q <= up ? dst_q - LenW'(1) : dst_q + LenW'(1);
      end
      if (ctl_i.copy_rd) cp_q <= cp_q + PlenW'(1);
      if (ctl_i.cmt_done) begin
        len_q  <= view_len;
        open_q <= 1'b0;
      end
      if (ctl_i.rd_issue) rd_sel_q <= open_q && vidx >= left && vrel < LenW'(plen_q);
      // simple commands
      if (ctl_i.exec) begin
        case (cmd)
          CMD_RIGHT: cur_q <= (sum > {1'b0, len_q}) ? len_q : sum[LenW-1:0];
          CMD_LEFT:  cur_q <= lft;
          CMD_SET:   cur_q <= (arg_x > 17'(len_q)) ? len_q : in_q.arg[LenW-1:0];
          CMD_INSERT: begin
            if (!open_q) begin
              open_q <= 1'b1; back_q <= '0; fwd_q <= '0;
              plen_q <= (len_q >= BufFull) ? '0 : PlenW'(1);
            end else if (!(view_len >= BufFull || plen_q >= PendFull)) begin
              plen_q <= plen_q + PlenW'(1);
            end
          end
          CMD_DELETE: begin
            if (!open_q) begin
              open_q <= 1'b1; back_q <= '0; plen_q <= '0;
              fwd_q <= (arg_x < 17'(len_q - cur_q)) ? in_q.arg[LenW-1:0]
                                                     : LenW'(len_q - cur_q);
            end else fwd_q <= fwd_q + k;
          end
          CMD_BACK: begin
            if (!open_q) begin
              open_q <= 1'b1; plen_q <= '0; fwd_q <= '0;
              back_q <= (arg_x < 17'(cur_q)) ? in_q.arg[LenW-1:0] : cur_q;
            end else begin
              plen_q <= plen_q - pk;
              back_q <= back_q + bk;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result word; view length after the command mirrors the state update
  logic [LenW-1:0] vl_after;
  logic [1:0]      st;
  logic            full_now;
  always_comb begin
    full_now = open_q ? (view_len >= BufFull || plen_q >= PendFull) : (len_q >= BufFull);
    st = ST_OK;
    vl_after = view_len;
    case (cmd)
      CMD_INSERT: begin
        if (full_now) st = ST_FULL;
        else vl_after = view_len + LenW'(1);
      end
      CMD_DELETE: vl_after = open_q ? view_len - k
          : ((arg_x < 17'(len_q - cur_q)) ? len_q - in_q.arg[LenW-1:0] : cur_q);
      CMD_BACK: vl_after = open_q ? view_len - LenW'(pk) - bk
          : ((arg_x < 17'(cur_q)) ? len_q - in_q.arg[LenW-1:0] : len_q - cur_q);
      CMD_READ: if (!(arg_x < 17'(view_len))) st = ST_RANGE;
      default: ;
    endcase
  end

  logic [LenW-1:0] cur_after;
  logic            open_after;
  always_comb begin
    cur_after  = cur_q;
    open_after = open_q;
    case (cmd)
      CMD_RIGHT: cur_after = (sum > {1'b0, len_q}) ? len_q : sum[LenW-1:0];
      CMD_LEFT:  cur_after = lft;
      CMD_SET:   cur_after = (arg_x > 17'(len_q)) ? len_q : in_q.arg[LenW-1:0];
      CMD_INSERT, CMD_DELETE, CMD_BACK: open_after = 1'b1;
      default: ;
    endcase
  end

  assign out_o = out_q;

  // result register; a read in range takes its byte from the RAM output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (ctl_i.respond) begin
      out_q.byte_out    <= (cmd == CMD_READ && st == ST_OK) ? (rd_sel_q ? px_rd : tx_rd)
                                                            : '0;
      out_q.view_length <= 11'(vl_after);
      out_q.cursor_pos  <= 11'(cur_after);
      out_q.editing     <= open_after;
      out_q.status      <= st;
    end
  end

  assign strobe_o = strobe_q;

endmodule

// ===== hw/rtl/line_edit_buffer.sv =====
`timescale 1ns / 1ps
// Line edit buffer: a text line with cursor and a pending edit overlay.
// Command channel: drive cmd/arg in in_i with start_i high while busy_o is
// low; the word is taken at that edge and busy_o rises the next cycle.
// Result channel: one word per command on out_o, marked by done_o for
// exactly one cycle. The receiver cannot stall; it must take it then.
// Sequence: an accepted word is decoded; an edit or move is then executed,
// a read in range issues its RAM read and takes the byte, and the result
// is registered onto out_o. A move while an edit is open first commits:
// the tail and then the pending bytes go into the text RAM, each byte in a
// read state and a write state, since RAM reads are registered. Tail and
// pending bytes together never exceed BufDepth. Throughput: one command at
// a time; busy_o drops in the cycle done_o is high, so the next word can be taken at its end.
// Reset: clears length, cursor and edit state; RAM contents stay undefined
// and are never read before written.
module line_edit_buffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  leb_pkg::in_word_t  in_i,
  output logic               busy_o,
  output logic               done_o,
  output leb_pkg::out_word_t out_o
);
  import leb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  leb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .ctl_o(ctl)
  );

  leb_dpath u_dpath (
    .clk_i, .rst_ni, .in_i, .ctl_i(ctl), .sts_o(sts), .out_o, .strobe_o(done_o)
  );

endmodule

// ===== hw/rtl/leb_checker.sv =====
`timescale 1ns / 1ps
module leb_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input leb_pkg::out_word_t out_o
);
  import leb_pkg::*;

  // an accepted word makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");

  // a result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // cursor never beyond view when not editing
  a_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_o.editing |-> out_o.cursor_pos <= out_o.view_length)
    else $error("cursor past end");

  // view never longer than capacity
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_o.view_length <= 11'(BufDepth)) else $error("overlong");

endmodule

bind line_edit_buffer leb_props u_leb_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .out_o
);
